### rtl/btff_pkg.sv
`default_nettype none
package btff_pkg;

	// byte addresses and block sizes; wide enough for a break pointer plus a full growth
	localparam int AW = 19;

	typedef logic [AW-1:0] addr_t;
	typedef logic [31:0]   word_t;

	localparam logic       KIND_ALLOC = 1'b0;
	localparam logic       KIND_FREE  = 1'b1;

	localparam word_t      ALLOC_BIT  = 32'h1;
	localparam addr_t      MIN_BLOCK  = AW'(16);
	localparam addr_t      INIT_CHUNK = AW'(1 << 12);
	localparam addr_t      SIZE_MASK  = ~AW'(7);

	function automatic addr_t tag_size(input word_t w);
		return w[AW-1:0] & SIZE_MASK;
	endfunction

endpackage
`default_nettype wire

### rtl/btff_ram.sv
`default_nettype none
module btff_ram #(
	parameter int WORDS = 16384
) (
	input  wire                clk,
	input  wire                en,
	input  wire                we,
	input  wire btff_pkg::addr_t addr,
	input  wire btff_pkg::word_t wdata,
	output btff_pkg::word_t    rdata
);
	import btff_pkg::*;

	localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;

	word_t           mem [WORDS];
	logic            in_range;
	logic [IW-1:0]   idx;

	assign in_range = (32'(addr[AW-1:2]) < 32'(WORDS));
	assign idx      = IW'(addr[AW-1:2]);

	always_ff @(posedge clk) begin
		if (en && we && in_range) begin
			mem[idx] <= wdata;
		end
	end

	// out-of-store words read as zero
	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= in_range ? mem[idx] : '0;
		end
	end

endmodule
`default_nettype wire

### rtl/boundary_tag_first_fit_allocator.sv
// Channel   Handshake                    Payload
// command   start / busy                 kind, request_bytes, block_address
// result    done (one-cycle strobe)      payload_address, failed
// config    cfg_valid / cfg_ready        cfg_data (chunk_bytes)
//
// Done is high in the first idle cycle after a command. Allocate walks the block headers,
// grows the heap if no free block fits (merging with a free last block; a refused growth
// fails it), then places the block, splitting it when the rest is large enough. Free checks
// the header, writes the tags and merges with free neighbours; a rejected free also ends in
// done. A zero-size allocate returns on the next cycle without going busy. After reset it is
// busy writing the initial tags. Tags use the single-port RAM; done is never held off.
`default_nettype none
module boundary_tag_first_fit_allocator #(
	parameter int HEAP_WORDS = 16384
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	output logic         busy,
	input  wire          kind,
	input  wire  [15:0]  request_bytes,
	input  wire  [15:0]  block_address,
	output logic         done,
	output logic [15:0]  payload_address,
	output logic         failed,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [16:0]  cfg_data
);
	import btff_pkg::*;

	localparam int    LIMIT_INT = (HEAP_WORDS * 4 > 65536) ? 65536 : HEAP_WORDS * 4;
	localparam addr_t LIMIT_B   = AW'(LIMIT_INT);

	typedef enum logic [4:0] {
		S_INIT0, S_INIT1, S_INIT2, S_INIT3,
		S_IDLE,
		S_WALK_ST, S_WALK,
		S_GROW, S_GW1, S_GW2, S_GW3,
		S_FREE_RD, S_FREE_CK, S_FREE_W1, S_FREE_W2,
		S_MG_PF, S_MG_H, S_MG_N, S_MG_D, S_MG_W1, S_MG_W2,
		S_PL1, S_PL2, S_PL3, S_PL4
	} state_t;

	typedef enum logic [1:0] {CTX_INIT, CTX_ALLOC, CTX_FREE} ctx_t;

	state_t  state_q;
	ctx_t    ctx_q;
	addr_t   bp_q, asize_q, csize_q, brk_q, mbp_q, msz_q, gsz_q;
	word_t   pf_q;
	logic [16:0] chunk_q;
	logic    done_q, fail_q;
	logic [15:0] pay_q;

	logic    mem_en, mem_we;
	addr_t   mem_addr;
	word_t   mem_wdata, mem_rdata;

	btff_ram #(.WORDS(HEAP_WORDS)) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// combinational helpers
	addr_t  rd_size, walk_next, req_asize, ext, grow_words, grow_sz, place_sz, rest;
	addr_t  psz, nsz, mg_base, mg_size;
	logic   split, fit, free_ok;

	always_comb begin
		rd_size    = tag_size(mem_rdata);
		walk_next  = bp_q + rd_size;
		req_asize  = (request_bytes <= 16'd8) ? MIN_BLOCK
		             : ((AW'(request_bytes) + AW'(15)) & SIZE_MASK);
		if (ctx_q == CTX_INIT) begin
			ext = INIT_CHUNK;
		end else begin
			ext = (asize_q > AW'(chunk_q)) ? asize_q : AW'(chunk_q);
		end
		grow_words = ext >> 2;
		grow_sz    = (grow_words + AW'(grow_words[0])) << 2;
		split      = (csize_q >= asize_q + MIN_BLOCK);
		place_sz   = split ? asize_q : csize_q;
		rest       = csize_q - asize_q;
		fit        = !mem_rdata[0] && (asize_q <= rd_size);
		free_ok    = (bp_q[2:0] == 3'b0) && (bp_q >= AW'(16)) && mem_rdata[0]
		             && (rd_size >= MIN_BLOCK) && (bp_q + rd_size <= brk_q);
		psz        = tag_size(pf_q);
		nsz        = rd_size;
		mg_base    = pf_q[0] ? mbp_q : (mbp_q - psz);
		mg_size    = msz_q + (pf_q[0] ? '0 : psz) + (mem_rdata[0] ? '0 : nsz);
	end

	// RAM port decode
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			S_INIT0: begin mem_en = 1'b1; mem_we = 1'b1; mem_addr = AW'(0);  mem_wdata = '0; end
			S_INIT1: begin mem_en = 1'b1; mem_we = 1'b1; mem_addr = AW'(4);  mem_wdata = 32'd8 | ALLOC_BIT; end
			S_INIT2: begin mem_en = 1'b1; mem_we = 1'b1; mem_addr = AW'(8);  mem_wdata = 32'd8 | ALLOC_BIT; end
			S_INIT3: begin mem_en = 1'b1; mem_we = 1'b1; mem_addr = AW'(12); mem_wdata = ALLOC_BIT; end
			S_GW1: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = brk_q - AW'(4); mem_wdata = 32'(gsz_q);
			end
			S_GW2: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = brk_q + gsz_q - AW'(8); mem_wdata = 32'(gsz_q);
			end
			S_GW3: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = brk_q + gsz_q - AW'(4); mem_wdata = ALLOC_BIT;
			end
			S_WALK_ST, S_FREE_RD: begin
				mem_en = 1'b1; mem_addr = bp_q - AW'(4);
			end
			S_WALK: begin
				mem_en = 1'b1; mem_addr = walk_next - AW'(4);
			end
			S_FREE_W1: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q - AW'(4); mem_wdata = 32'(csize_q);
			end
			S_FREE_W2: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q + csize_q - AW'(8); mem_wdata = 32'(csize_q);
			end
			S_MG_PF: begin mem_en = 1'b1; mem_addr = mbp_q - AW'(8); end
			S_MG_H:  begin mem_en = 1'b1; mem_addr = mbp_q - AW'(4); end
			S_MG_N:  begin mem_en = 1'b1; mem_addr = mbp_q + rd_size - AW'(4); end
			S_MG_W1: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = mbp_q - AW'(4); mem_wdata = 32'(msz_q);
			end
			S_MG_W2: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = mbp_q + msz_q - AW'(8); mem_wdata = 32'(msz_q);
			end
			S_PL1: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q - AW'(4); mem_wdata = 32'(place_sz) | ALLOC_BIT;
			end
			S_PL2: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q + place_sz - AW'(8); mem_wdata = 32'(place_sz) | ALLOC_BIT;
			end
			S_PL3: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q + asize_q - AW'(4); mem_wdata = 32'(rest);
			end
			S_PL4: begin
				mem_en = 1'b1; mem_we = 1'b1;
				mem_addr = bp_q + csize_q - AW'(8); mem_wdata = 32'(rest);
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			ctx_q   <= CTX_INIT;
			brk_q   <= AW'(16);
			chunk_q <= 17'd4096;
			done_q  <= 1'b0;
			fail_q  <= 1'b0;
			pay_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				chunk_q <= cfg_data;
			end
			unique case (state_q)
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_INIT2;
				S_INIT2: state_q <= S_INIT3;
				S_INIT3: begin
					brk_q   <= AW'(16);
					ctx_q   <= CTX_INIT;
					state_q <= S_GROW;
				end
				S_IDLE: begin
					if (start) begin
						bp_q    <= AW'(block_address);
						asize_q <= req_asize;
						if (kind == KIND_FREE) begin
							ctx_q   <= CTX_FREE;
							state_q <= S_FREE_RD;
						end else if (request_bytes == 16'd0) begin
							done_q <= 1'b1;
							fail_q <= 1'b1;
							pay_q  <= '0;
						end else begin
							ctx_q   <= CTX_ALLOC;
							bp_q    <= AW'(8);
							state_q <= S_WALK_ST;
						end
					end
				end
				S_WALK_ST: state_q <= S_WALK;
				S_WALK: begin
					// stop at the epilogue or past the break, take the first free fit
					if (rd_size == '0) begin
						state_q <= S_GROW;
					end else if (fit) begin
						csize_q <= rd_size;
						state_q <= S_PL1;
					end else if (walk_next > brk_q) begin
						state_q <= S_GROW;
					end else begin
						bp_q <= walk_next;
					end
				end
				S_GROW: begin
					if (grow_sz == '0 || brk_q + grow_sz > LIMIT_B) begin
						if (ctx_q == CTX_ALLOC) begin
							done_q <= 1'b1;
							fail_q <= 1'b1;
							pay_q  <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						gsz_q   <= grow_sz;
						state_q <= S_GW1;
					end
				end
				S_GW1: state_q <= S_GW2;
				S_GW2: state_q <= S_GW3;
				S_GW3: begin
					mbp_q   <= brk_q;
					brk_q   <= brk_q + gsz_q;
					state_q <= S_MG_PF;
				end
				S_FREE_RD: state_q <= S_FREE_CK;
				S_FREE_CK: begin
					csize_q <= rd_size;
					if (free_ok) begin
						state_q <= S_FREE_W1;
					end else begin
						done_q  <= 1'b1;
						fail_q  <= 1'b0;
						pay_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_FREE_W1: state_q <= S_FREE_W2;
				S_FREE_W2: begin
					mbp_q   <= bp_q;
					state_q <= S_MG_PF;
				end
				S_MG_PF: state_q <= S_MG_H;
				S_MG_H: begin
					pf_q    <= mem_rdata;
					state_q <= S_MG_N;
				end
				S_MG_N: begin
					msz_q   <= rd_size;
					state_q <= S_MG_D;
				end
				S_MG_D: begin
					if (pf_q[0] && mem_rdata[0]) begin
						bp_q    <= mbp_q;
						csize_q <= msz_q;
						if (ctx_q == CTX_ALLOC) begin
							state_q <= S_PL1;
						end else begin
							done_q  <= (ctx_q == CTX_FREE);
							fail_q  <= 1'b0;
							pay_q   <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						mbp_q   <= mg_base;
						msz_q   <= mg_size;
						state_q <= S_MG_W1;
					end
				end
				S_MG_W1: state_q <= S_MG_W2;
				S_MG_W2: begin
					bp_q    <= mbp_q;
					csize_q <= msz_q;
					if (ctx_q == CTX_ALLOC) begin
						state_q <= S_PL1;
					end else begin
						done_q  <= (ctx_q == CTX_FREE);
						fail_q  <= 1'b0;
						pay_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_PL1: state_q <= S_PL2;
				S_PL2: begin
					if (split) begin
						state_q <= S_PL3;
					end else begin
						done_q  <= 1'b1;
						fail_q  <= 1'b0;
						pay_q   <= bp_q[15:0];
						state_q <= S_IDLE;
					end
				end
				S_PL3: state_q <= S_PL4;
				S_PL4: begin
					done_q  <= 1'b1;
					fail_q  <= 1'b0;
					pay_q   <= bp_q[15:0];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign failed          = fail_q;
	assign payload_address = pay_q;
	assign cfg_ready       = 1'b1;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !(kind == KIND_ALLOC && request_bytes == 16'd0)) |=> busy)
		else $error("accepted command did not go busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && failed) |-> (payload_address == 16'd0))
		else $error("failed result carries an address");

	a_brk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(brk_q <= LIMIT_B) && (brk_q[2:0] == 3'b0))
		else $error("break pointer out of range or misaligned");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_pay_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (payload_address[2:0] == 3'b0))
		else $error("payload address not 8-byte aligned");

endmodule
`default_nettype wire

### tb/boundary_tag_first_fit_allocator_tb.sv
`default_nettype none
module boundary_tag_first_fit_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btff_pkg::*;

	localparam int WORDS = 16384;
	localparam longint unsigned LIMIT = 65536;
	localparam longint unsigned MASK8 = ~64'h7;
	localparam longint unsigned USED = 64'h1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_ALLOC;
	logic [15:0] request_bytes = '0;
	logic [15:0] block_address = '0;
	logic        cfg_valid = 1'b0;
	logic [16:0] cfg_data = '0;
	wire         busy, done, failed, cfg_ready;
	wire  [15:0] payload_address;

	boundary_tag_first_fit_allocator #(.HEAP_WORDS(WORDS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.request_bytes(request_bytes), .block_address(block_address), .done(done),
		.payload_address(payload_address), .failed(failed), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// heap image kept by the predictor
	logic [31:0]     heap_img [WORDS];
	bit              tag_seen [WORDS];
	longint unsigned brk_ptr;
	longint unsigned chunk_sz;

	typedef struct packed {
		logic [15:0] addr;
		logic        fail;
	} outcome_t;
	outcome_t        pending_q[$];
	logic [15:0]     live_q[$];
	logic [15:0]     dead_q[$];
	int              errs = 0;

	function automatic longint unsigned hrd(longint unsigned a);
		longint unsigned i;
		i = a >> 2;
		if (i >= WORDS) return 0;
		return 64'(heap_img[i[13:0]]);
	endfunction

	function automatic void hwr(longint unsigned a, longint unsigned v);
		longint unsigned i;
		i = a >> 2;
		if (i < WORDS) begin
			heap_img[i[13:0]] = v[31:0];
			tag_seen[i[13:0]] = 1'b1;
		end
	endfunction

	function automatic longint unsigned blk_size(longint unsigned bp);
		return hrd(bp - 4) & MASK8;
	endfunction

	function automatic bit blk_used(longint unsigned bp);
		return (hrd(bp - 4) & USED) != 0;
	endfunction

	function automatic longint unsigned coalesce(longint unsigned bp);
		longint unsigned pf, psz, prv, sz, nh, nsz;
		bit pa, na;
		pf = hrd(bp - 8);
		psz = pf & MASK8;
		prv = bp - psz;
		sz = blk_size(bp);
		nh = hrd(bp + sz - 4);
		nsz = nh & MASK8;
		pa = (pf & USED) != 0;
		na = (nh & USED) != 0;
		if (pa && na) return bp;
		if (pa) begin
			sz += nsz;
			hwr(bp - 4, sz & MASK8);
			hwr(bp + sz - 8, sz & MASK8);
			return bp;
		end
		sz += psz;
		if (!na) sz += nsz;
		hwr(prv - 4, sz & MASK8);
		hwr(prv + sz - 8, sz & MASK8);
		return prv;
	endfunction

	function automatic bit grow_heap(longint unsigned bytes, output longint unsigned blk);
		longint unsigned w, sz, bp;
		w = bytes / 4;
		sz = (w + (w & 1)) * 4;
		bp = brk_ptr;
		blk = 0;
		if (sz == 0 || bp + sz > LIMIT) return 1'b0;
		hwr(bp - 4, sz);
		hwr(bp + sz - 8, sz);
		hwr(bp + sz - 4, USED);
		brk_ptr = bp + sz;
		blk = coalesce(bp);
		return 1'b1;
	endfunction

	function automatic bit scan_fit(longint unsigned asz, output longint unsigned blk);
		longint unsigned bp, s;
		bp = 8;
		blk = 0;
		while (bp <= brk_ptr) begin
			s = blk_size(bp);
			if (s == 0) return 1'b0;
			if (!blk_used(bp) && asz <= s) begin
				blk = bp;
				return 1'b1;
			end
			bp += s;
		end
		return 1'b0;
	endfunction

	function automatic void carve(longint unsigned bp, longint unsigned asz);
		longint unsigned cs, rest;
		cs = blk_size(bp);
		if (cs >= asz + 16) begin
			rest = cs - asz;
			hwr(bp - 4, asz | USED);
			hwr(bp + asz - 8, asz | USED);
			hwr(bp + asz - 4, rest);
			hwr(bp + cs - 8, rest);
		end else begin
			hwr(bp - 4, cs | USED);
			hwr(bp + cs - 8, cs | USED);
		end
	endfunction

	function automatic void heap_init();
		longint unsigned b;
		foreach (heap_img[i]) begin
			heap_img[i] = '0;
			tag_seen[i] = 1'b0;
		end
		chunk_sz = 4096;
		hwr(0, 0);
		hwr(4, 8 | USED);
		hwr(8, 8 | USED);
		hwr(12, USED);
		brk_ptr = 16;
		void'(grow_heap(4096, b));
	endfunction

	function automatic outcome_t heap_op(logic k, logic [15:0] req, logic [15:0] a16);
		outcome_t r;
		longint unsigned asz, blk, ext, a, s;
		bit ok;
		r = '0;
		a = 64'(a16);
		if (k == KIND_ALLOC) begin
			if (req == 0) begin
				r.fail = 1'b1;
			end else begin
				asz = (req <= 8) ? 16 : ((longint'(req) + 15) / 8) * 8;
				ok = scan_fit(asz, blk);
				if (!ok) begin
					ext = (asz > chunk_sz) ? asz : chunk_sz;
					ok = grow_heap(ext, blk);
				end
				if (ok) begin
					carve(blk, asz);
					r.addr = blk[15:0];
				end else begin
					r.fail = 1'b1;
				end
			end
		end else begin
			s = blk_size(a);
			if ((a & 7) == 0 && a >= 16 && blk_used(a) && s >= 16 && a + s <= brk_ptr) begin
				hwr(a - 4, s);
				hwr(a + s - 8, s);
				void'(coalesce(a));
			end
		end
		return r;
	endfunction

	// a free may only touch a header word that has been written
	function automatic bit header_known(logic [15:0] a);
		logic [13:0] wi;
		if (a < 4) return 1'b1;
		wi = a[15:2] - 14'd1;
		return tag_seen[wi];
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result addr=%0d failed=%0b", $time,
					payload_address, failed);
				errs++;
			end else begin
				if (payload_address !== pending_q[0].addr) begin
					$display("%0t: payload_address expected %0d actual %0d", $time,
						pending_q[0].addr, payload_address);
					errs++;
				end
				if (failed !== pending_q[0].fail) begin
					$display("%0t: failed expected %0b actual %0b", $time,
						pending_q[0].fail, failed);
					errs++;
				end
				void'(pending_q.pop_front());
			end
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic issue(logic k, logic [15:0] req, logic [15:0] a, int gap,
		bit fixed, outcome_t want);
		outcome_t r;
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		kind = k;
		request_bytes = req;
		block_address = a;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = heap_op(k, req, a);
		if (k == KIND_ALLOC && !r.fail) live_q.push_back(r.addr);
		pending_q.push_back(fixed ? want : r);
	endtask

	task automatic set_chunk(logic [16:0] v);
		@(negedge clk);
		start = 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		chunk_sz = 64'(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	typedef struct {
		logic        k;
		logic [15:0] req;
		logic [15:0] a;
		bit          fixed;
		logic [15:0] ea;
		logic        ef;
	} row_t;

	row_t rows[] = '{
		'{KIND_ALLOC, 16'd1,     16'd0,     1, 16'd16, 1'b0},
		'{KIND_FREE,  16'hFFFF,  16'd16,    1, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd8,     16'hFFFF,  1, 16'd16, 1'b0},
		'{KIND_ALLOC, 16'd9,     16'd0,     1, 16'd32, 1'b0},
		'{KIND_ALLOC, 16'd0,     16'd0,     1, 16'd0,  1'b1},
		'{KIND_ALLOC, 16'hFFFF,  16'd0,     1, 16'd0,  1'b1},
		'{KIND_FREE,  16'd0,     16'd0,     1, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd4,     1, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd8,     1, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd20,    1, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd100,   16'd0,     0, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd4000,  16'd0,     0, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd40,    16'd0,     0, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd32,    0, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd32,    1, 16'd0,  1'b0},
		'{KIND_FREE,  16'd0,     16'd16,    0, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd60000, 16'd0,     0, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd7,     16'd0,     0, 16'd0,  1'b0},
		'{KIND_ALLOC, 16'd24,    16'd0,     0, 16'd0,  1'b0}
	};

	logic [16:0] chunk_plan[] = '{17'd8, 17'd65536, 17'd0, 17'h1FFFF, 17'd1, 17'd4096};

	task automatic random_item();
		int p, idx;
		logic [15:0] a, req;
		outcome_t none;
		none = '0;
		p = $urandom_range(0, 99);
		req = 16'($urandom_range(0, 65535));
		if (p < 55) begin
			idx = $urandom_range(0, 99);
			if (idx < 70) req = 16'($urandom_range(1, 256));
			else if (idx < 95) req = 16'($urandom_range(257, 3000));
			else if (idx < 97) req = 16'd0;
			a = 16'($urandom_range(0, 65535));
			issue(KIND_ALLOC, req, a, pick_gap(), 0, none);
		end else begin
			if (p < 88 && live_q.size() != 0) begin
				idx = $urandom_range(0, live_q.size() - 1);
				a = live_q[idx];
				live_q.delete(idx);
				dead_q.push_back(a);
				if (dead_q.size() > 32) void'(dead_q.pop_front());
			end else if (p < 93 && dead_q.size() != 0) begin
				a = dead_q[$urandom_range(0, dead_q.size() - 1)];
			end else if (p < 96 && live_q.size() != 0) begin
				a = 16'(live_q[$urandom_range(0, live_q.size() - 1)]
					+ 4 * $urandom_range(1, 3));
			end else begin
				a = 16'($urandom_range(0, 65535));
			end
			if (!header_known(a)) a = 16'd8;
			issue(KIND_FREE, req, a, pick_gap(), 0, none);
		end
	endtask

	initial begin
		heap_init();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i])
			issue(rows[i].k, rows[i].req, rows[i].a, (i % 3 == 2) ? 2 : 0,
				rows[i].fixed, '{rows[i].ea, rows[i].ef});
		foreach (chunk_plan[ph]) begin
			set_chunk(chunk_plan[ph]);
			repeat (280) random_item();
		end
		set_chunk(17'($urandom_range(1, 512) * 8));
		repeat (20) random_item();
		@(negedge clk);
		start = 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errs == 0)
			$display("boundary_tag_first_fit_allocator_tb: clean");
		else
			$display("boundary_tag_first_fit_allocator_tb: errors");
		$finish;
	end

	initial begin
		#500ms;
		$display("boundary_tag_first_fit_allocator_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/btff_pkg.sv
rtl/btff_ram.sv
rtl/boundary_tag_first_fit_allocator.sv
tb/boundary_tag_first_fit_allocator_tb.sv
